FILE: hdl/avm_pkg.sv
// ----------------------------------------------------------------------------
// avm_pkg
// shared widths, types and the segment table of the averaging voltmeter
// ----------------------------------------------------------------------------
package avm_pkg;

    localparam int SAMPLES_LOG2 = 3;
    localparam int ADC_BITS     = 10;
    localparam int SAMPLE_W     = 10;
    localparam int SUM_W        = ADC_BITS + SAMPLES_LOG2;
    localparam int CNT_W        = (SAMPLES_LOG2 > 0) ? SAMPLES_LOG2 : 1;
    localparam int GROUP_SIZE   = 1 << SAMPLES_LOG2;
    localparam int FULL_SCALE   = (1 << ADC_BITS) - 1;
    localparam int SCALE_MUL    = 33;
    localparam int PROD_W       = ADC_BITS + 6;
    localparam int TENTHS_W     = 7;
    localparam int TENTHS_MAX   = 99;
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    typedef logic [ADC_BITS-1:0]  t_adc;
    typedef logic [SUM_W-1:0]     t_sum;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [ADC_BITS:0]    t_rem;
    typedef logic [PROD_W-1:0]    t_prod;
    typedef logic [TENTHS_W-1:0]  t_tenths;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_UPDATE,
        CMD_REFRESH
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_adc  avg;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_req;

    typedef struct packed {
        logic                func;
        logic [SAMPLE_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [7:0] voltage_bcd;
        logic       value_updated;
        logic       drive_valid;
        logic [6:0] segments;
        logic       high_digit_on;
        logic       low_digit_on;
    } t_out;

    localparam logic [6:0] SEG_TABLE [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
    };

endpackage

FILE: hdl/adc_average_voltmeter_display_top.sv
// ----------------------------------------------------------------------------
// adc_average_voltmeter_display_top
// path: an accepted request is written into the command queue and from there
// into the output register of the back part, which offers the result
// throughput: one request per cycle while the output is taken, set by the
// two-entry command queue and the single output register of the back part
// reset: synchronous active-low, clears sum, count, held voltage, digit
// select, queue and output valid
// ----------------------------------------------------------------------------
module adc_average_voltmeter_display_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  avm_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output avm_pkg::t_out o_out_data
);

    avm_pkg::t_q_req push;
    avm_pkg::t_q_req pop;
    logic            q_full;
    logic            pop_ready;

    avm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push)
    );

    avm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (q_full),
        .o_pop       (pop),
        .i_pop_ready (pop_ready)
    );

    avm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop       (pop),
        .o_pop_ready (pop_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: hdl/avm_front.sv
// ----------------------------------------------------------------------------
// avm_front
// accepts requests, accumulates sample groups and queues classified commands
// ----------------------------------------------------------------------------
module avm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  avm_pkg::t_in      i_in_data,
    input  logic              i_q_full,
    output avm_pkg::t_q_req   o_push
);

    avm_pkg::t_sum r_sum, n_sum;
    avm_pkg::t_cnt r_count, n_count;
    avm_pkg::t_sum sum_next;
    logic          accept;
    logic          complete;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign complete   = (r_count == avm_pkg::t_cnt'(avm_pkg::GROUP_SIZE - 1));
    assign sum_next   = r_sum + avm_pkg::t_sum'(avm_pkg::t_adc'(i_in_data.sample));

    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        o_push.valid   = accept;
        o_push.cmd.avg = avm_pkg::t_adc'(sum_next >> avm_pkg::SAMPLES_LOG2);
        if (i_in_data.func) begin
            o_push.cmd.kind = avm_pkg::CMD_REFRESH;
        end else if (complete) begin
            o_push.cmd.kind = avm_pkg::CMD_UPDATE;
        end else begin
            o_push.cmd.kind = avm_pkg::CMD_SAMPLE;
        end
        if (accept && !i_in_data.func) begin
            if (complete) begin
                n_sum   = '0;
                n_count = '0;
            end else begin
                n_sum   = sum_next;
                n_count = r_count + avm_pkg::t_cnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_sum   <= n_sum;
            r_count <= n_count;
        end
    end

endmodule

FILE: hdl/avm_queue.sv
// ----------------------------------------------------------------------------
// avm_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module avm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  avm_pkg::t_q_req i_push,
    output logic            o_full,
    output avm_pkg::t_q_req o_pop,
    input  logic            i_pop_ready
);

    avm_pkg::t_cmd                r_mem [avm_pkg::Q_DEPTH];
    logic [avm_pkg::Q_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [avm_pkg::Q_CNT_W-1:0]  r_count;
    logic                         push;
    logic                         pop;

    assign o_full      = (r_count == avm_pkg::Q_CNT_W'(avm_pkg::Q_DEPTH));
    assign o_pop.valid = (r_count != '0);
    assign o_pop.cmd   = r_mem[r_rd_ptr];
    assign push        = i_push.valid && !o_full;
    assign pop         = i_pop_ready && o_pop.valid;

    function automatic logic [avm_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [avm_pkg::Q_PTR_W-1:0] ptr
    );
        if (ptr == avm_pkg::Q_PTR_W'(avm_pkg::Q_DEPTH - 1)) begin
            return '0;
        end
        return ptr + avm_pkg::Q_PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + avm_pkg::Q_CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - avm_pkg::Q_CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= avm_pkg::Q_CNT_W'(avm_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full)
        else $error("request queued while queue full");

endmodule

FILE: hdl/avm_back.sv
// ----------------------------------------------------------------------------
// avm_back
// executes queued commands: voltage scaling, digit multiplexing, result register
// ----------------------------------------------------------------------------
module avm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  avm_pkg::t_q_req i_pop,
    output logic            o_pop_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output avm_pkg::t_out   o_out_data
);

    logic [7:0]     r_held, n_held;
    logic           r_sel, n_sel;
    logic           r_out_valid;
    avm_pkg::t_out  r_out, n_out;
    logic           pop;

    function automatic logic [7:0] scale_bcd(input avm_pkg::t_adc avg);
        avm_pkg::t_prod                                x;
        logic [avm_pkg::PROD_W-avm_pkg::ADC_BITS-1:0] q0;
        avm_pkg::t_rem                                 r;
        avm_pkg::t_tenths                              q;
        avm_pkg::t_tenths                              units;
        logic [3:0]                                    tens;
        x  = avm_pkg::t_prod'(avg) * avm_pkg::t_prod'(avm_pkg::SCALE_MUL)
           + avm_pkg::t_prod'(avm_pkg::FULL_SCALE / 2);
        q0 = x[avm_pkg::PROD_W-1:avm_pkg::ADC_BITS];
        // x = q0 * full + q0 + low bits, remainder stays below twice full scale
        r  = {1'b0, x[avm_pkg::ADC_BITS-1:0]} + avm_pkg::t_rem'(q0);
        q  = avm_pkg::t_tenths'(q0)
           + avm_pkg::t_tenths'(r >= avm_pkg::t_rem'(avm_pkg::FULL_SCALE));
        if (q > avm_pkg::t_tenths'(avm_pkg::TENTHS_MAX)) begin
            q = avm_pkg::t_tenths'(avm_pkg::TENTHS_MAX);
        end
        tens = '0;
        for (int i = 1; i < 10; i++) begin
            if (q >= avm_pkg::t_tenths'(10 * i)) begin
                tens = 4'(i);
            end
        end
        units = q - avm_pkg::t_tenths'({tens, 3'b000}) - avm_pkg::t_tenths'({tens, 1'b0});
        return {tens, units[3:0]};
    endfunction

    assign o_pop_ready = !r_out_valid || i_out_ready;
    assign pop         = i_pop.valid && o_pop_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_held = r_held;
        n_sel  = r_sel;
        n_out  = '0;
        case (i_pop.cmd.kind)
            avm_pkg::CMD_UPDATE: begin
                n_held              = scale_bcd(i_pop.cmd.avg);
                n_out.value_updated = 1'b1;
            end
            avm_pkg::CMD_REFRESH: begin
                n_out.drive_valid = 1'b1;
                if (!r_sel) begin
                    n_out.segments      = avm_pkg::SEG_TABLE[r_held[7:4]];
                    n_out.high_digit_on = 1'b1;
                end else begin
                    n_out.segments      = avm_pkg::SEG_TABLE[r_held[3:0]];
                    n_out.low_digit_on  = 1'b1;
                end
                n_sel = !r_sel;
            end
            default: begin
            end
        endcase
        n_out.voltage_bcd = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_held      <= n_held;
                r_sel       <= n_sel;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_update_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.value_updated) |-> !o_out_data.drive_valid)
        else $error("update and display drive in one result");

    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.drive_valid)
            |-> (o_out_data.high_digit_on ^ o_out_data.low_digit_on))
        else $error("refresh result must enable exactly one digit");

    a_quiet_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.drive_valid)
            |-> (o_out_data.segments == '0 && !o_out_data.high_digit_on
                 && !o_out_data.low_digit_on))
        else $error("sample result drives the display");

    a_held_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.voltage_bcd == r_held))
        else $error("result voltage differs from held voltage");

endmodule
